/* rtl/hue_selective_color_splash_defines.svh */
// Assertion macros for the hue selective color splash block.
// Included by files that carry concurrent checks; expects clock and reset in scope.
`ifndef HUE_SELECTIVE_COLOR_SPLASH_DEFINES_SVH
`define HUE_SELECTIVE_COLOR_SPLASH_DEFINES_SVH

// same-cycle implication
`define HSC_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HSC_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/hsc_pkg.sv */
// Shared types and constants of the hue selective color splash block.
// Holds the register map, reset values, gray weights and the hue table generator.
package hsc_pkg;

   typedef logic [7:0] pixel_type;
   typedef logic [1:0] csr_index_type;

   localparam int CSR_DATA_W = 10;

   localparam csr_index_type CSR_TARGET_HUE    = 2'd0;
   localparam csr_index_type CSR_HUE_TOLERANCE = 2'd1;
   localparam csr_index_type CSR_GAIN_Q8       = 2'd2;

   localparam logic [8:0] TARGET_HUE_RST    = 9'd240;
   localparam logic [7:0] HUE_TOLERANCE_RST = 8'd30;
   localparam logic [9:0] GAIN_Q8_RST       = 10'd307;

   localparam logic [15:0] GRAY_W_RED   = 16'd19661;
   localparam logic [15:0] GRAY_W_GREEN = 16'd38666;
   localparam logic [15:0] GRAY_W_BLUE  = 16'd7209;

   localparam logic [8:0] HUE_FULL_TURN = 9'd360;
   localparam logic [8:0] HUE_HALF_TURN = 9'd180;

   localparam longint unsigned Q30_ONE      = 64'd1073741824;
   localparam longint unsigned Q30_HALF     = 64'd536870912;
   localparam longint unsigned COS_HALF_DEG = 64'd1073700939;
   localparam longint unsigned SIN_HALF_DEG = 64'd9370046;

   // arccosine in degrees of (idx - h) / h, counted over half-degree cosine steps
   function automatic logic [8:0] hue_rom_entry(input int idx, input int h);
      longint unsigned c;
      longint unsigned s;
      longint unsigned nc;
      longint unsigned ns;
      longint          x;
      longint          cv;
      int              cnt;
      c   = Q30_ONE;
      s   = 64'd0;
      cnt = 0;
      x   = longint'(idx - h) * longint'(Q30_ONE);
      for (int step = 1; step <= 179; step++) begin
         nc = (c * COS_HALF_DEG - s * SIN_HALF_DEG + Q30_HALF) >> 30;
         ns = (s * COS_HALF_DEG + c * SIN_HALF_DEG + Q30_HALF) >> 30;
         c  = nc;
         s  = ns;
         if (step[0]) begin
            cv = longint'(c);
            if (x <= cv * longint'(h)) cnt++;
            if (x <= -(cv * longint'(h))) cnt++;
         end
      end
      return 9'(cnt);
   endfunction

endpackage

/* rtl/hsc_if.sv */
// Pixel request and response channel interfaces of the hue selective color splash.
// Depends on hsc_pkg for the pixel type.
interface hsc_req_if import hsc_pkg::*;;
   logic      valid;
   logic      ready;
   pixel_type red_in;
   pixel_type green_in;
   pixel_type blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   input ready);
   modport sink   (input valid, input red_in, input green_in, input blue_in,
                   output ready);
endinterface

interface hsc_rsp_if import hsc_pkg::*;;
   logic      valid;
   logic      ready;
   pixel_type red_out;
   pixel_type green_out;
   pixel_type blue_out;
   logic      kept_color;

   modport source (output valid, output red_out, output green_out, output blue_out,
                   output kept_color, input ready);
   modport sink   (input valid, input red_out, input green_out, input blue_out,
                   input kept_color, output ready);
endinterface

/* rtl/hue_selective_color_splash.sv */
// Top level of the hue selective color splash: HSI hue keying with boost or gray.
// Depends on hsc_pkg, hsc_if and hue_selective_color_splash_defines.svh.
//
//   channel   | direction | payload                                      | handshake
//   req_bus   | in        | red_in, green_in, blue_in                    | valid/ready
//   rsp_bus   | out       | red_out, green_out, blue_out, kept_color     | valid/ready
//   csr_*     | in        | csr_index, csr_wdata                         | csr_we
//
// One request per cycle unless rsp_bus stalls; 5 + 2*clog2(2*HUE_TABLE_HALF_STEPS+1) register
// stages (21 at 100); the hue search resolves one index bit per two stages.
// Each stage advances when it is empty or the stage after it advances, so bubbles close up.
// Reset is synchronous; it clears valid bits and loads CSR reset values; no clearing pass.
`include "hue_selective_color_splash_defines.svh"

module hue_selective_color_splash
   import hsc_pkg::*;
#(
   parameter int HUE_TABLE_HALF_STEPS = 100
) (
   input  logic                  clock,
   input  logic                  reset,
   hsc_req_if.sink               req_bus,
   hsc_rsp_if.source             rsp_bus,
   input  logic                  csr_we,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int H         = HUE_TABLE_HALF_STEPS;
   localparam int ROM_DEPTH = 2 * H + 1;
   localparam int IW        = $clog2(ROM_DEPTH);
   localparam int TW        = IW + 1;
   localparam int SQW       = 2 * IW;
   localparam int AW        = $clog2(H * 510 + 1);
   localparam int ASQW      = 2 * AW;
   localparam int PW        = SQW + 19;
   localparam int CW        = (PW > ASQW) ? PW : ASQW;
   localparam int SRCH      = 2 * IW;
   localparam int ST_HUE    = 3 + SRCH;
   localparam int NST       = 5 + SRCH;

   typedef struct packed {
      pixel_type        red;
      pixel_type        green;
      pixel_type        blue;
      logic [16:0]      dsum;
      logic [AW:0]      anum;
      logic             a_neg;
      logic [ASQW-1:0]  asq;
      logic [IW-1:0]    idx;
      logic [IW-1:0]    cand;
      logic             cand_ok;
      logic             tpos;
      logic [SQW-1:0]   tsq;
      logic [8:0]       hue;
      pixel_type        red_boost;
      pixel_type        green_boost;
      pixel_type        blue_boost;
      pixel_type        gray;
      logic             keep;
   } stage_type;

   logic [8:0]       target_hue_ff;
   logic [7:0]       hue_tolerance_ff;
   logic [9:0]       gain_q8_ff;
   stage_type        pipe_ff [NST];
   stage_type        pipe_in [NST];
   logic [NST-1:0]   v_ff;
   logic [NST-1:0]   en;
   logic [8:0]       rom_tbl [ROM_DEPTH];

   // hue table
   for (genvar gi = 0; gi < ROM_DEPTH; gi++) begin : g_rom
      localparam logic [8:0] ENTRY = hue_rom_entry(gi, H);
      assign rom_tbl[gi] = ENTRY;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_hue_ff    <= TARGET_HUE_RST;
         hue_tolerance_ff <= HUE_TOLERANCE_RST;
         gain_q8_ff       <= GAIN_Q8_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET_HUE:    target_hue_ff    <= csr_wdata[8:0];
            CSR_HUE_TOLERANCE: hue_tolerance_ff <= csr_wdata[7:0];
            CSR_GAIN_Q8:       gain_q8_ff       <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // advance chain
   always_comb begin
      en[NST-1] = !v_ff[NST-1] || rsp_bus.ready;
      for (int k = NST - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_bus.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= req_bus.valid;
         for (int k = 1; k < NST; k++) begin
            if (en[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NST; k++) begin
         if (en[k]) pipe_ff[k] <= pipe_in[k];
      end
   end

   // capture pixel
   always_comb begin
      pipe_in[0]       = '0;
      pipe_in[0].red   = req_bus.red_in;
      pipe_in[0].green = req_bus.green_in;
      pipe_in[0].blue  = req_bus.blue_in;
   end

   // difference energy and scaled numerator
   logic signed [8:0]  d_rg, d_rb, d_gb;
   logic        [17:0] dsum2;
   logic signed [10:0] num;
   always_comb begin
      d_rg  = $signed({1'b0, pipe_ff[0].red})   - $signed({1'b0, pipe_ff[0].green});
      d_rb  = $signed({1'b0, pipe_ff[0].red})   - $signed({1'b0, pipe_ff[0].blue});
      d_gb  = $signed({1'b0, pipe_ff[0].green}) - $signed({1'b0, pipe_ff[0].blue});
      dsum2 = 18'(d_rg * d_rg) + 18'(d_rb * d_rb) + 18'(d_gb * d_gb);
      num   = $signed({2'b0, pipe_ff[0].red, 1'b0}) - $signed({3'b0, pipe_ff[0].green})
            - $signed({3'b0, pipe_ff[0].blue});
      pipe_in[1]      = pipe_ff[0];
      pipe_in[1].dsum = dsum2[17:1];
      pipe_in[1].anum = (AW+1)'(num * H);
   end

   // squared numerator
   logic [AW-1:0] aabs;
   always_comb begin
      aabs = pipe_ff[1].anum[AW] ? AW'(-$signed(pipe_ff[1].anum)) : pipe_ff[1].anum[AW-1:0];
      pipe_in[2]       = pipe_ff[1];
      pipe_in[2].a_neg = pipe_ff[1].anum[AW];
      pipe_in[2].asq   = ASQW'(aabs) * ASQW'(aabs);
      pipe_in[2].idx   = '0;
   end

   // index search, one bit per stage pair
   for (genvar gi = 0; gi < IW; gi++) begin : g_search
      localparam int KX  = 3 + 2 * gi;
      localparam int BIT = IW - 1 - gi;
      logic [IW-1:0]        cand;
      logic signed [TW-1:0] tval;
      logic [IW-1:0]        tabs;
      logic [CW-1:0]        lhs;
      logic [CW-1:0]        rhs;
      logic                 pass;

      always_comb begin
         cand = pipe_ff[KX-1].idx | (IW'(1) << BIT);
         tval = $signed({1'b0, cand}) - $signed(TW'(H));
         tabs = tval[TW-1] ? IW'(-tval) : tval[IW-1:0];
         pipe_in[KX]         = pipe_ff[KX-1];
         pipe_in[KX].cand    = cand;
         pipe_in[KX].cand_ok = cand <= IW'(2 * H);
         pipe_in[KX].tpos    = !tval[TW-1] && (tval != '0);
         pipe_in[KX].tsq     = SQW'(tabs) * SQW'(tabs);
      end

      always_comb begin
         lhs = (CW'(pipe_ff[KX].tsq) * CW'(pipe_ff[KX].dsum)) << 2;
         rhs = CW'(pipe_ff[KX].asq);
         priority if (!pipe_ff[KX].tpos && !pipe_ff[KX].a_neg) pass = 1'b1;
         else if (pipe_ff[KX].tpos && pipe_ff[KX].a_neg)       pass = 1'b0;
         else if (pipe_ff[KX].tpos)                            pass = lhs <= rhs;
         else                                                  pass = lhs >= rhs;
         pipe_in[KX+1] = pipe_ff[KX];
         if (pipe_ff[KX].cand_ok && pass) pipe_in[KX+1].idx = pipe_ff[KX].cand;
      end
   end

   // hue lookup, boost and gray
   logic [8:0]  hue_base;
   logic [17:0] pr_r, pr_g, pr_b;
   logic [23:0] gray_sum;
   always_comb begin
      hue_base = (pipe_ff[ST_HUE-1].dsum == '0) ? 9'd0 : rom_tbl[pipe_ff[ST_HUE-1].idx];
      pr_r     = 18'(pipe_ff[ST_HUE-1].red)   * 18'(gain_q8_ff);
      pr_g     = 18'(pipe_ff[ST_HUE-1].green) * 18'(gain_q8_ff);
      pr_b     = 18'(pipe_ff[ST_HUE-1].blue)  * 18'(gain_q8_ff);
      gray_sum = 24'(pipe_ff[ST_HUE-1].red)   * 24'(GRAY_W_RED)
               + 24'(pipe_ff[ST_HUE-1].green) * 24'(GRAY_W_GREEN)
               + 24'(pipe_ff[ST_HUE-1].blue)  * 24'(GRAY_W_BLUE);
      pipe_in[ST_HUE]     = pipe_ff[ST_HUE-1];
      pipe_in[ST_HUE].hue = (pipe_ff[ST_HUE-1].blue > pipe_ff[ST_HUE-1].green)
                          ? HUE_FULL_TURN - hue_base : hue_base;
      pipe_in[ST_HUE].red_boost   = (pr_r[17:16] != 2'b0) ? 8'hFF : pr_r[15:8];
      pipe_in[ST_HUE].green_boost = (pr_g[17:16] != 2'b0) ? 8'hFF : pr_g[15:8];
      pipe_in[ST_HUE].blue_boost  = (pr_b[17:16] != 2'b0) ? 8'hFF : pr_b[15:8];
      pipe_in[ST_HUE].gray        = gray_sum[23:16];
   end

   // circular distance and select
   logic signed [10:0] hue_diff;
   logic signed [10:0] dist_fix;
   logic        [10:0] adist;
   logic        [10:0] adist_fix;
   logic               keep;
   always_comb begin
      hue_diff  = $signed({2'b0, pipe_ff[ST_HUE].hue}) - $signed({2'b0, target_hue_ff});
      adist     = hue_diff[10] ? 11'(-hue_diff) : hue_diff;
      dist_fix  = hue_diff;
      if (adist > 11'(HUE_HALF_TURN)) begin
         if (pipe_ff[ST_HUE].hue < target_hue_ff)
            dist_fix = hue_diff + $signed({2'b0, HUE_FULL_TURN});
         else dist_fix = hue_diff - $signed({2'b0, HUE_FULL_TURN});
      end
      adist_fix = dist_fix[10] ? 11'(-dist_fix) : dist_fix;
      keep      = adist_fix <= 11'(hue_tolerance_ff);
      pipe_in[NST-1]      = pipe_ff[ST_HUE];
      pipe_in[NST-1].keep = keep;
      if (!keep) begin
         pipe_in[NST-1].red_boost   = pipe_ff[ST_HUE].gray;
         pipe_in[NST-1].green_boost = pipe_ff[ST_HUE].gray;
         pipe_in[NST-1].blue_boost  = pipe_ff[ST_HUE].gray;
      end
   end

   assign rsp_bus.valid      = v_ff[NST-1];
   assign rsp_bus.red_out    = pipe_ff[NST-1].red_boost;
   assign rsp_bus.green_out  = pipe_ff[NST-1].green_boost;
   assign rsp_bus.blue_out   = pipe_ff[NST-1].blue_boost;
   assign rsp_bus.kept_color = pipe_ff[NST-1].keep;

   `HSC_ASSERT_IMP(a_gray_equal, rsp_bus.valid && !rsp_bus.kept_color, rsp_bus.red_out == rsp_bus.green_out && rsp_bus.green_out == rsp_bus.blue_out, "gray response with unequal channels")
   `HSC_ASSERT_IMP(a_idx_range, v_ff[ST_HUE-1], pipe_ff[ST_HUE-1].idx <= IW'(2 * H), "hue index beyond table")
   `HSC_ASSERT_IMP(a_flat_zero, v_ff[2] && pipe_ff[2].dsum == '0, pipe_ff[2].asq == '0, "flat pixel with nonzero numerator")
   `HSC_ASSERT_NXT(a_req_taken, req_bus.valid && req_bus.ready, v_ff[0], "accepted request not held in first stage")

endmodule
